// ===== src/ctt_pkg.sv =====
// shared types, constants and helper functions for the config text tokenizer
package ctt_pkg;

  // counter widths
  localparam int LINE_BITS  = 16;
  localparam int DEPTH_BITS = 16;
  localparam int LINE_OUT_W = 16;

  // byte codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // input function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOT  = 1'b1;

  // lexer modes
  typedef enum logic [2:0] {
    M_LSTART  = 3'd0,
    M_GAP     = 3'd1,
    M_WORD    = 3'd2,
    M_QUOTE   = 3'd3,
    M_ESC     = 3'd4,
    M_COMMENT = 3'd5,
    M_ERROR   = 3'd6
  } mode_t;

  // token kinds
  typedef enum logic [2:0] {
    K_SSTART = 3'd0,
    K_SBYTE  = 3'd1,
    K_SEND   = 3'd2,
    K_OPEN   = 3'd3,
    K_CLOSE  = 3'd4,
    K_SEMI   = 3'd5,
    K_END    = 3'd6,
    K_ERR    = 3'd7
  } kind_t;

  // error codes
  localparam logic [1:0] E_UNTERM    = 2'd0;
  localparam logic [1:0] E_UNEXP     = 2'd1;
  localparam logic [1:0] E_MISSING   = 2'd2;
  localparam logic [1:0] E_TOO_DEEP  = 2'd3;
  localparam logic [1:0] E_NONE      = 2'd0;

  // lexer state
  typedef struct packed {
    mode_t                 mode;
    logic                  qsingle;
    logic [DEPTH_BITS-1:0] depth;
    logic [LINE_BITS-1:0]  lcount;
    logic                  alb;
    logic                  uf_seen;
    logic [LINE_BITS-1:0]  uf_line;
  } st_t;

  // one token event
  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            tbyte;
    logic [LINE_OUT_W-1:0] line;
    logic [1:0]            code;
  } ev_t;

  // up to two events caused by one word
  typedef struct packed {
    ev_t        e0;
    ev_t        e1;
    logic [1:0] n;
  } evlist_t;

  function automatic st_t st_reset();
    st_t s;
    s.mode    = M_LSTART;
    s.qsingle = 1'b0;
    s.depth   = '0;
    s.lcount  = '0;
    s.alb     = 1'b1;
    s.uf_seen = 1'b0;
    s.uf_line = '0;
    return s;
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_special(logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_SEMI);
  endfunction

  // low output bits of a line count, zero-extended when the count is narrow
  function automatic logic [LINE_OUT_W-1:0] line_out(logic [LINE_BITS-1:0] l);
    logic [LINE_BITS+LINE_OUT_W-1:0] wide;
    wide = {{LINE_OUT_W{1'b0}}, l};
    return wide[LINE_OUT_W-1:0];
  endfunction

  function automatic ev_t mk_ev(kind_t k, logic [7:0] b, logic [LINE_BITS-1:0] l,
                                logic [1:0] c);
    ev_t e;
    e.kind  = k;
    e.tbyte = (k == K_SBYTE) ? b : 8'h00;
    e.line  = line_out(l);
    e.code  = (k == K_ERR) ? c : E_NONE;
    return e;
  endfunction

  // append an event; the list never holds more than two
  function automatic evlist_t push(evlist_t l, ev_t e);
    evlist_t r;
    r = l;
    if (l.n == 2'd0) begin
      r.e0 = e;
      r.n  = 2'd1;
    end else if (l.n == 2'd1) begin
      r.e1 = e;
      r.n  = 2'd2;
    end
    return r;
  endfunction

endpackage

// ===== src/ctt_lexer.sv =====
// combinational lexer step: next state and token events for one word
module ctt_lexer (
  input  logic              func,
  input  logic [7:0]        text_byte,
  input  ctt_pkg::st_t      st,
  output ctt_pkg::st_t      st_next,
  output ctt_pkg::evlist_t  evs
);

  localparam logic [ctt_pkg::LINE_BITS-1:0]  LMAX = '1;
  localparam logic [ctt_pkg::DEPTH_BITS-1:0] DMAX = '1;

  ctt_pkg::st_t     s;
  ctt_pkg::evlist_t l;
  logic [ctt_pkg::LINE_BITS-1:0] line;
  logic do_gap;
  logic qchar_hit;

  always_comb begin
    s         = st;
    l         = '0;
    line      = st.lcount;
    do_gap    = 1'b0;
    qchar_hit = st.qsingle ? (text_byte == ctt_pkg::CH_SQUOTE)
                           : (text_byte == ctt_pkg::CH_DQUOTE);

    if (func == ctt_pkg::FUNC_EOT) begin
      // end of text: flush word, check braces or report an open quote, back to reset
      case (st.mode)
        ctt_pkg::M_LSTART, ctt_pkg::M_GAP, ctt_pkg::M_WORD, ctt_pkg::M_COMMENT: begin
          if (st.mode == ctt_pkg::M_WORD)
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SEND, 8'h00, line,
                                                ctt_pkg::E_NONE));
          if (st.uf_seen)
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, st.uf_line,
                                                ctt_pkg::E_UNEXP));
          else if (st.depth != '0)
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, line,
                                                ctt_pkg::E_MISSING));
          else
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_END, 8'h00, line,
                                                ctt_pkg::E_NONE));
        end
        ctt_pkg::M_QUOTE, ctt_pkg::M_ESC: begin
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, line,
                                              ctt_pkg::E_UNTERM));
        end
        default: begin
        end
      endcase
      s = ctt_pkg::st_reset();
    end else begin
      // line counting on the first byte of a line
      if ((st.mode <= ctt_pkg::M_COMMENT) && st.alb) begin
        if (st.lcount != LMAX)
          s.lcount = st.lcount + 1'b1;
        s.alb = 1'b0;
      end
      line = s.lcount;

      case (st.mode)
        ctt_pkg::M_COMMENT: begin
          if (text_byte == ctt_pkg::CH_NL) begin
            s.mode = ctt_pkg::M_LSTART;
            s.alb  = 1'b1;
          end
        end
        ctt_pkg::M_QUOTE: begin
          if (text_byte == ctt_pkg::CH_NL) begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, line,
                                                ctt_pkg::E_UNTERM));
            s.mode = ctt_pkg::M_ERROR;
          end else if (qchar_hit) begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SEND, 8'h00, line,
                                                ctt_pkg::E_NONE));
            s.mode = ctt_pkg::M_GAP;
          end else begin
            if (text_byte == ctt_pkg::CH_BSLASH)
              s.mode = ctt_pkg::M_ESC;
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SBYTE, text_byte, line,
                                                ctt_pkg::E_NONE));
          end
        end
        ctt_pkg::M_ESC: begin
          if (text_byte == ctt_pkg::CH_NL) begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, line,
                                                ctt_pkg::E_UNTERM));
            s.mode = ctt_pkg::M_ERROR;
          end else begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SBYTE, text_byte, line,
                                                ctt_pkg::E_NONE));
            s.mode = ctt_pkg::M_QUOTE;
          end
        end
        ctt_pkg::M_WORD: begin
          if (ctt_pkg::is_ws(text_byte) || ctt_pkg::is_special(text_byte)) begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SEND, 8'h00, line,
                                                ctt_pkg::E_NONE));
            s.mode = ctt_pkg::M_GAP;
            do_gap = 1'b1;
          end else begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SBYTE, text_byte, line,
                                                ctt_pkg::E_NONE));
          end
        end
        ctt_pkg::M_LSTART, ctt_pkg::M_GAP: begin
          do_gap = 1'b1;
        end
        default: begin
        end
      endcase

      // byte between tokens
      if (do_gap) begin
        if (text_byte == ctt_pkg::CH_NL) begin
          s.mode = ctt_pkg::M_LSTART;
          s.alb  = 1'b1;
        end else if (ctt_pkg::is_ws(text_byte)) begin
          // stay in the current mode
        end else if ((s.mode == ctt_pkg::M_LSTART) && (text_byte == ctt_pkg::CH_HASH)) begin
          s.mode = ctt_pkg::M_COMMENT;
        end else if (text_byte == ctt_pkg::CH_LBRACE) begin
          if (st.depth == DMAX) begin
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_ERR, 8'h00, line,
                                                ctt_pkg::E_TOO_DEEP));
            s.mode = ctt_pkg::M_ERROR;
          end else begin
            s.depth = st.depth + 1'b1;
            s.mode  = ctt_pkg::M_GAP;
            l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_OPEN, 8'h00, line,
                                                ctt_pkg::E_NONE));
          end
        end else if (text_byte == ctt_pkg::CH_RBRACE) begin
          s.mode = ctt_pkg::M_GAP;
          if (st.depth == '0) begin
            if (!st.uf_seen) begin
              s.uf_seen = 1'b1;
              s.uf_line = line;
            end
          end else begin
            s.depth = st.depth - 1'b1;
          end
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_CLOSE, 8'h00, line,
                                              ctt_pkg::E_NONE));
        end else if (text_byte == ctt_pkg::CH_SEMI) begin
          s.mode = ctt_pkg::M_GAP;
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SEMI, 8'h00, line,
                                              ctt_pkg::E_NONE));
        end else if ((text_byte == ctt_pkg::CH_DQUOTE) ||
                     (text_byte == ctt_pkg::CH_SQUOTE)) begin
          s.qsingle = (text_byte == ctt_pkg::CH_SQUOTE);
          s.mode    = ctt_pkg::M_QUOTE;
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SSTART, 8'h00, line,
                                              ctt_pkg::E_NONE));
        end else begin
          s.mode = ctt_pkg::M_WORD;
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SSTART, 8'h00, line,
                                              ctt_pkg::E_NONE));
          l = ctt_pkg::push(l, ctt_pkg::mk_ev(ctt_pkg::K_SBYTE, text_byte, line,
                                              ctt_pkg::E_NONE));
        end
      end
    end

    st_next = s;
    evs     = l;
  end

endmodule

// ===== src/ctt_outbuf.sv =====
// two-entry result register that hands out the token events of one word one at a time
module ctt_outbuf (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  ctt_pkg::evlist_t                    evs,
  output logic                                free,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          kind,
  output logic [7:0]                          token_byte,
  output logic [ctt_pkg::LINE_OUT_W-1:0]      line_number,
  output logic [1:0]                          error_code,
  output logic                                last
);

  logic             valid;
  logic             idx;
  ctt_pkg::evlist_t buf_evs;
  ctt_pkg::ev_t     cur;

  // current entry and its last flag
  always_comb begin
    cur  = idx ? buf_evs.e1 : buf_evs.e0;
    last = idx || (buf_evs.n == 2'd1);
    free = !valid || (out_ready && last);
  end

  assign out_valid   = valid;
  assign kind        = cur.kind;
  assign token_byte  = cur.tbyte;
  assign line_number = cur.line;
  assign error_code  = cur.code;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 1'b0;
    end else if (valid && out_ready) begin
      if (last)
        valid <= 1'b0;
      else
        idx <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load)
      buf_evs <= evs;
  end

endmodule

// ===== src/config_text_tokenizer_top.sv =====
// top level of the config text tokenizer: input register, lexer state and result register
//
// Lexes configuration text one byte per word; one word can be taken every clock
// cycle unless a full result register holds it back. A byte first lands in an
// input register; when its events fit, the lexer updates its state and writes the
// zero, one or two token events it causes into a two-entry result register, which
// hands them out one per cycle while the receiver is ready. A word that causes two
// events holds back the next, so the drain rate sets the sustained throughput: one
// word per cycle for words with at most one event and a ready receiver. End of text
// (func high) flushes an open word, reports the brace check and returns the lexer to
// its reset state. The line number saturates; a brace nested too deep is an error.
module config_text_tokenizer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [7:0]                      text_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      kind,
  output logic [7:0]                      token_byte,
  output logic [ctt_pkg::LINE_OUT_W-1:0]  line_number,
  output logic [1:0]                      error_code,
  output logic                            last
);

  logic             s1_valid;
  logic             s1_func;
  logic [7:0]       s1_byte;
  ctt_pkg::st_t     st;
  ctt_pkg::st_t     st_next;
  ctt_pkg::evlist_t evs;
  logic             ob_free;
  logic             adv;

  // the input word moves on when its events fit in the result register
  assign adv      = s1_valid && ((evs.n == 2'd0) || ob_free);
  assign in_ready = !s1_valid || adv;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_byte <= text_byte;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ctt_pkg::st_reset();
    end else if (adv) begin
      st <= st_next;
    end
  end

  ctt_lexer u_lexer (
    .func      (s1_func),
    .text_byte (s1_byte),
    .st        (st),
    .st_next   (st_next),
    .evs       (evs)
  );

  ctt_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (adv && (evs.n != 2'd0)),
    .evs         (evs),
    .free        (ob_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .token_byte  (token_byte),
    .line_number (line_number),
    .error_code  (error_code),
    .last        (last)
  );

endmodule

// ===== tb/config_text_tokenizer_checker.sv =====
// token predictor and scoreboard for the config text tokenizer testbench
`timescale 1ns / 1ps

module config_text_tokenizer_checker
  import ctt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  func,
  input  logic [7:0]            text_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            kind,
  input  logic [7:0]            token_byte,
  input  logic [LINE_OUT_W-1:0] line_number,
  input  logic [1:0]            error_code,
  input  logic                  last,
  output int                    fail_count,
  output int                    tokens_pending
);

  // one expected token event
  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            tbyte;
    logic [LINE_OUT_W-1:0] line;
    logic [1:0]            code;
    logic                  last;
  } tok_t;

  // predicted lexer state
  mode_t                 lmode;
  logic                  qsingle;
  logic [DEPTH_BITS-1:0] depth;
  logic [LINE_BITS-1:0]  lines;
  logic                  line_fresh;
  logic                  uf_seen;
  logic [LINE_BITS-1:0]  uf_line;

  tok_t token_q[$];
  tok_t burst[$];

  initial fail_count = 0;
  initial tokens_pending = 0;

  task automatic clear_lexer();
    lmode      = M_LSTART;
    qsingle    = 1'b0;
    depth      = '0;
    lines      = '0;
    line_fresh = 1'b1;
    uf_seen    = 1'b0;
    uf_line    = '0;
  endtask

  function automatic logic blank_byte(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic delim_byte(logic [7:0] b);
    return b == CH_LBRACE || b == CH_RBRACE || b == CH_SEMI;
  endfunction

  // a word causes at most two events
  task automatic emit(input kind_t k, input logic [7:0] b, input logic [LINE_BITS-1:0] ln,
                      input logic [1:0] c);
    tok_t t;
    if (burst.size() < 2) begin
      t.kind  = k;
      t.tbyte = (k == K_SBYTE) ? b : 8'h00;
      t.line  = ln[LINE_OUT_W-1:0];
      t.code  = (k == K_ERR) ? c : E_NONE;
      t.last  = 1'b0;
      burst   = {burst, t};
    end
  endtask

  task automatic lex_error(input logic [1:0] c, input logic [LINE_BITS-1:0] ln);
    emit(K_ERR, 8'h00, ln, c);
    lmode = M_ERROR;
  endtask

  // byte seen at line start or between tokens
  task automatic between_tokens(input logic [7:0] b, input logic [LINE_BITS-1:0] ln);
    if (b == CH_NL) begin
      lmode      = M_LSTART;
      line_fresh = 1'b1;
    end else if (blank_byte(b)) begin
      // stay
    end else if (lmode == M_LSTART && b == CH_HASH) begin
      lmode = M_COMMENT;
    end else if (b == CH_LBRACE) begin
      lmode = M_GAP;
      if (depth == '1) begin
        lex_error(E_TOO_DEEP, ln);
      end else begin
        depth = depth + 1'b1;
        emit(K_OPEN, 8'h00, ln, E_NONE);
      end
    end else if (b == CH_RBRACE) begin
      lmode = M_GAP;
      if (depth == '0) begin
        if (!uf_seen) begin
          uf_seen = 1'b1;
          uf_line = ln;
        end
      end else begin
        depth = depth - 1'b1;
      end
      emit(K_CLOSE, 8'h00, ln, E_NONE);
    end else if (b == CH_SEMI) begin
      lmode = M_GAP;
      emit(K_SEMI, 8'h00, ln, E_NONE);
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      qsingle = (b == CH_SQUOTE);
      lmode   = M_QUOTE;
      emit(K_SSTART, 8'h00, ln, E_NONE);
    end else begin
      lmode = M_WORD;
      emit(K_SSTART, 8'h00, ln, E_NONE);
      emit(K_SBYTE, b, ln, E_NONE);
    end
  endtask

  // work out the events caused by one accepted word
  task automatic tokenize_word(input logic f, input logic [7:0] b);
    logic [7:0] close_q;
    burst.delete();
    if (f == FUNC_EOT) begin
      case (lmode)
        M_LSTART, M_GAP, M_WORD, M_COMMENT: begin
          if (lmode == M_WORD) emit(K_SEND, 8'h00, lines, E_NONE);
          if (uf_seen) emit(K_ERR, 8'h00, uf_line, E_UNEXP);
          else if (depth != '0) emit(K_ERR, 8'h00, lines, E_MISSING);
          else emit(K_END, 8'h00, lines, E_NONE);
        end
        M_QUOTE, M_ESC: emit(K_ERR, 8'h00, lines, E_UNTERM);
        default: ;
      endcase
      clear_lexer();
    end else begin
      if (lmode <= M_COMMENT && line_fresh) begin
        if (lines != '1) lines = lines + 1'b1;
        line_fresh = 1'b0;
      end
      close_q = qsingle ? CH_SQUOTE : CH_DQUOTE;
      case (lmode)
        M_COMMENT: begin
          if (b == CH_NL) begin
            lmode      = M_LSTART;
            line_fresh = 1'b1;
          end
        end
        M_QUOTE: begin
          if (b == CH_NL) begin
            lex_error(E_UNTERM, lines);
          end else if (b == close_q) begin
            emit(K_SEND, 8'h00, lines, E_NONE);
            lmode = M_GAP;
          end else begin
            if (b == CH_BSLASH) lmode = M_ESC;
            emit(K_SBYTE, b, lines, E_NONE);
          end
        end
        M_ESC: begin
          if (b == CH_NL) begin
            lex_error(E_UNTERM, lines);
          end else begin
            emit(K_SBYTE, b, lines, E_NONE);
            lmode = M_QUOTE;
          end
        end
        M_WORD: begin
          if (blank_byte(b) || delim_byte(b)) begin
            emit(K_SEND, 8'h00, lines, E_NONE);
            lmode = M_GAP;
            between_tokens(b, lines);
          end else begin
            emit(K_SBYTE, b, lines, E_NONE);
          end
        end
        M_LSTART, M_GAP: between_tokens(b, lines);
        default: ;
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    token_q = {token_q, burst};
  endtask

  // compare one accepted token event with the oldest prediction
  task automatic check_token();
    tok_t exp_tok;
    if (token_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected token: expected none, got kind %0d byte %02h line %0d",
               $time, kind, token_byte, line_number);
      $display("  code %0d last %0b", error_code, last);
    end else begin
      exp_tok = token_q.pop_front();
      if (kind != exp_tok.kind || token_byte != exp_tok.tbyte ||
          line_number != exp_tok.line || error_code != exp_tok.code ||
          last != exp_tok.last) begin
        fail_count++;
        $display("%0t: token differs: expected kind %0d byte %02h line %0d code %0d last %0b",
                 $time, exp_tok.kind, exp_tok.tbyte, exp_tok.line, exp_tok.code,
                 exp_tok.last);
        $display("  got kind %0d byte %02h line %0d code %0d last %0b",
                 kind, token_byte, line_number, error_code, last);
      end
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      clear_lexer();
      token_q.delete();
    end else begin
      if (in_valid && in_ready) tokenize_word(func, text_byte);
      if (out_valid && out_ready) check_token();
    end
    tokens_pending = token_q.size();
  end

endmodule

// ===== tb/config_text_tokenizer_top_tb.sv =====
// stimulus, clocking and verdict for the config text tokenizer testbench
`timescale 1ns / 1ps

module config_text_tokenizer_top_tb;
  import ctt_pkg::*;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_BYTE;
  logic [7:0]            text_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            kind;
  logic [7:0]            token_byte;
  logic [LINE_OUT_W-1:0] line_number;
  logic [1:0]            error_code;
  logic                  last;

  int fail_count;
  int tokens_pending;
  int send_idle = 9;
  int recv_idle = 62;
  int words_sent = 0;
  int stall_cycles = 0;
  logic [7:0] text_q[$];

  config_text_tokenizer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .text_byte(text_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .token_byte(token_byte),
    .line_number(line_number), .error_code(error_code), .last(last)
  );

  config_text_tokenizer_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .text_byte(text_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .token_byte(token_byte),
    .line_number(line_number), .error_code(error_code), .last(last),
    .fail_count(fail_count), .tokens_pending(tokens_pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle);

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("config_text_tokenizer_top: mismatch");
      $finish;
    end
  end

  // offer one word, called and returning at a falling edge
  task automatic put_word(input logic f, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_word(FUNC_BYTE, s[i]);
  endtask

  task automatic end_text();
    put_word(FUNC_EOT, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_CR;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CH_LBRACE || c == CH_RBRACE || c == CH_SEMI || c == CH_DQUOTE ||
           c == CH_SQUOTE);
    if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(128, 255));
    return c;
  endfunction

  task automatic add_sep();
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_NL);
    else repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
  endtask

  task automatic add_word();
    repeat ($urandom_range(1, 5)) text_q.push_back(word_char());
  endtask

  // quoted string with escapes; now and then left open or broken by a newline
  task automatic add_quoted();
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    text_q.push_back(q);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 6) == 0) begin
        text_q.push_back(CH_BSLASH);
        do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
        text_q.push_back(c);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_NL || c == q || c == CH_BSLASH);
        text_q.push_back(c);
      end
    end
    case ($urandom_range(0, 39))
      0: text_q.push_back(CH_NL);
      1: ;
      default: text_q.push_back(q);
    endcase
  endtask

  // one random config text followed by end of text
  task automatic send_config();
    int open_cnt;
    int pick;
    logic [7:0] b;
    text_q.delete();
    open_cnt = 0;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        if ($urandom_range(0, 1)) text_q.push_back(blank_char());
        text_q.push_back(CH_HASH);
        add_word();
        text_q.push_back(CH_NL);
      end else if (pick < 30 && open_cnt < 4) begin
        add_word();
        add_sep();
        text_q.push_back(CH_LBRACE);
        open_cnt++;
        add_sep();
      end else if (pick < 45 && open_cnt > 0) begin
        text_q.push_back(CH_RBRACE);
        open_cnt--;
        add_sep();
      end else begin
        add_word();
        add_sep();
        if ($urandom_range(0, 1)) add_quoted();
        else add_word();
        text_q.push_back(CH_SEMI);
        add_sep();
      end
    end
    if ($urandom_range(0, 9) != 0) repeat (open_cnt) text_q.push_back(CH_RBRACE);
    foreach (text_q[i]) begin
      b = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255)) : text_q[i];
      put_word(FUNC_BYTE, b);
    end
    end_text();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // comment line, word closed by a brace, escaped quote, stray close brace
    send_text("#z\nw{'\\'';}}");
    end_text();
    // extreme byte values in a word closed by newline
    put_word(FUNC_BYTE, 8'h00);
    put_word(FUNC_BYTE, 8'hFF);
    put_word(FUNC_BYTE, CH_NL);
    end_text();
    // newline inside quotes, then ignored bytes
    send_text("\"a\nx");
    end_text();
    // missing close brace
    put_word(FUNC_BYTE, CH_LBRACE);
    end_text();
    // quote open at end of text
    put_word(FUNC_BYTE, CH_DQUOTE);
    end_text();
    // empty text
    end_text();

    while (words_sent < 170) send_config();

    send_idle = 62;
    recv_idle = 9;
    while (words_sent < 340) send_config();

    send_idle = 0;
    recv_idle = 0;
    while (words_sent < 510) send_config();
    in_valid <= 1'b0;

    while (tokens_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("config_text_tokenizer_top: match");
    else $display("config_text_tokenizer_top: mismatch");
    $finish;
  end

endmodule
